@@ rtl/cnr_pkg.sv @@
// cnr_pkg: shared constants, widths and the arctangent table for complex_nth_roots.
// No dependencies.
package cnr_pkg;

    localparam int MAX_DEGREE_DEF   = 64;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 24;

    localparam int GUARD = 8;
    localparam int XW    = 44;   // CORDIC x/y width, guard bits included
    localparam int ZW    = 34;   // CORDIC angle accumulator width

    localparam logic [31:0] ANGLE_PI      = 32'h8000_0000;
    localparam logic [31:0] ANGLE_HALF_PI = 32'h4000_0000;
    localparam logic [31:0] ANGLE_NEG_HP  = 32'hC000_0000;
    localparam logic [31:0] KINV_Q30      = 32'd652032874;

    function automatic logic [31:0] cnr_atan(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/complex_nth_roots.sv @@
// complex_nth_roots: top level, sequencer around shared CORDIC step, multiplier
// and divider. Depends on cnr_pkg, cnr_mul, cnr_cordic_step, cnr_div.
//
// Usage: the input channel (s_valid/s_ready) takes a degree n and a radicand
// in signed Q(32-FRAC_BITS).FRAC_BITS. The result channel (m_valid/m_ready)
// then delivers n roots in order k = 0..n-1, m_last on the final one.
// Degree 0 acts as 1, degrees above MAX_DEGREE as MAX_DEGREE. Degree 1 echoes
// the radicand; a zero radicand gives one zero root.
// s_ready is high only while idle; one input transaction is processed at a time.
// Sequence to the first root: CORDIC vectoring (skipped for a radicand on an
// axis), two divisions in the shared divider, then the bit-serial n-th root
// search through the shared multiplier, then CORDIC rotation. Each further root
// takes another rotation on the shared CORDIC unit plus an output transaction.
// Degree 1 and zero radicand go straight from classification to the output.
// The next input is taken in the cycle after the last root.
// A stalled receiver holds the result register; the sequencer waits.
// Reset (aresetn, synchronous) returns the sequencer to idle and drops m_valid.
module complex_nth_roots
    import cnr_pkg::*;
#(
    parameter int MAX_DEGREE   = MAX_DEGREE_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [6:0]  s_degree,
    input  logic [31:0] s_real_in,
    input  logic [31:0] s_imag_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_root_index,
    output logic [31:0] m_real_out,
    output logic [31:0] m_imag_out,
    output logic        m_last
);
    localparam logic [5:0] LAST_STEP = 6'(CORDIC_STEPS - 1);
    localparam logic [6:0] MAX_N     = 7'(MAX_DEGREE);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_CLASS    = 5'd1;
    localparam logic [4:0] S_VEC      = 5'd2;
    localparam logic [4:0] S_MG_LO    = 5'd3;
    localparam logic [4:0] S_MG_HI    = 5'd4;
    localparam logic [4:0] S_MG_FIN   = 5'd5;
    localparam logic [4:0] S_DIV_B    = 5'd6;
    localparam logic [4:0] S_WAIT_B   = 5'd7;
    localparam logic [4:0] S_DIV_S    = 5'd8;
    localparam logic [4:0] S_WAIT_S   = 5'd9;
    localparam logic [4:0] S_RT_BIT   = 5'd10;
    localparam logic [4:0] S_RT_LO    = 5'd11;
    localparam logic [4:0] S_RT_HI    = 5'd12;
    localparam logic [4:0] S_RT_CHK   = 5'd13;
    localparam logic [4:0] S_X0_MUL   = 5'd14;
    localparam logic [4:0] S_X0_FIN   = 5'd15;
    localparam logic [4:0] S_ROT_INIT = 5'd16;
    localparam logic [4:0] S_ROT      = 5'd17;
    localparam logic [4:0] S_ROT_FIN  = 5'd18;
    localparam logic [4:0] S_OUT      = 5'd19;

    logic [4:0]  state_reg, state_next;
    logic [6:0]  n_reg, n_next;
    logic [31:0] re_reg, re_next, im_reg, im_next;
    logic signed [XW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic [5:0]  i_reg, i_next;
    logic [31:0] u_reg, u_next, mag_reg, mag_next;
    logic [31:0] base_reg, base_next, step_reg, step_next, theta_reg, theta_next;
    logic [31:0] r_reg, r_next, c_reg, c_next;
    logic [63:0] p_reg, p_next, lo_reg, lo_next;
    logic [4:0]  bit_reg, bit_next;
    logic [6:0]  j_reg, j_next, idx_reg, idx_next;
    logic [39:0] x0_reg, x0_next;
    logic        flip_reg, flip_next;
    logic        mv_reg, mv_next, ml_reg, ml_next;
    logic [5:0]  mk_reg, mk_next;
    logic [31:0] mre_reg, mre_next, mim_reg, mim_next;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic signed [XW-1:0] cx, cy;
    logic signed [ZW-1:0] cz;
    logic        cw;
    logic        div_start, div_done;
    logic [32:0] div_dividend, div_q;
    logic [95:0] sum96, q96;
    logic [63:0] target;
    logic        arg_neg;
    logic [31:0] abs_arg;
    logic [6:0]  n_clamp;
    logic [31:0] th_flip;
    logic signed [XW-1:0] xf, yf;

    function automatic logic [31:0] round_sat(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] t;
        logic signed [XW-GUARD-1:0] s;
        t = v + XW'(signed'(1 << (GUARD - 1)));
        s = (XW-GUARD)'(t >>> GUARD);
        if (s > (XW-GUARD)'(signed'(32'sh7FFF_FFFF)))
            return 32'h7FFF_FFFF;
        else if (s < (XW-GUARD)'(signed'(32'sh8000_0000)))
            return 32'h8000_0000;
        else
            return s[31:0];
    endfunction

    cnr_mul u_mul (.aclk(aclk), .a(mul_a), .b(mul_b), .prod(mul_p));

    cnr_cordic_step u_step (
        .x_in(x_reg), .y_in(y_reg), .z_in(z_reg), .shift(i_reg[4:0]), .cw(cw),
        .x_out(cx), .y_out(cy), .z_out(cz)
    );

    cnr_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(div_dividend), .divisor(n_reg), .done(div_done), .quotient(div_q)
    );

    always_comb begin
        cw      = (state_reg == S_VEC) ? (y_reg > 0) : (z_reg < 0);
        sum96   = {mul_p, 32'd0} + {32'd0, lo_reg};
        q96     = sum96 >> FRAC_BITS;
        target  = {32'd0, mag_reg} << (32 - FRAC_BITS);
        arg_neg = u_reg > ANGLE_PI;
        abs_arg = arg_neg ? (32'd0 - u_reg) : u_reg;
        th_flip = theta_reg - ANGLE_PI;
        xf      = flip_reg ? -x_reg : x_reg;
        yf      = flip_reg ? -y_reg : y_reg;
        if (s_degree == 7'd0)
            n_clamp = 7'd1;
        else if (s_degree > MAX_N)
            n_clamp = MAX_N;
        else
            n_clamp = s_degree;

        unique case (state_reg)
            S_MG_LO:  mul_a = x_reg[31:0];
            S_MG_HI:  mul_a = 32'(x_reg[XW-1:32]);
            S_RT_LO:  mul_a = p_reg[31:0];
            S_RT_HI:  mul_a = p_reg[63:32];
            default:  mul_a = r_reg;
        endcase
        mul_b = (state_reg == S_RT_LO || state_reg == S_RT_HI) ? c_reg : KINV_Q30;

        div_start    = (state_reg == S_DIV_B) || (state_reg == S_DIV_S);
        div_dividend = (state_reg == S_DIV_S) ? 33'h1_0000_0000 : {1'b0, abs_arg};
    end

    always_comb begin
        state_next = state_reg;
        n_next = n_reg;  re_next = re_reg;  im_next = im_reg;
        x_next = x_reg;  y_next = y_reg;  z_next = z_reg;  i_next = i_reg;
        u_next = u_reg;  mag_next = mag_reg;
        base_next = base_reg;  step_next = step_reg;  theta_next = theta_reg;
        r_next = r_reg;  c_next = c_reg;  p_next = p_reg;  lo_next = lo_reg;
        bit_next = bit_reg;  j_next = j_reg;  idx_next = idx_reg;
        x0_next = x0_reg;  flip_next = flip_reg;
        mv_next = mv_reg;  ml_next = ml_reg;  mk_next = mk_reg;
        mre_next = mre_reg;  mim_next = mim_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    n_next = n_clamp;
                    re_next = s_real_in;
                    im_next = s_imag_in;
                    state_next = S_CLASS;
                end
            end
            S_CLASS: begin
                idx_next = 7'd0;
                if (n_reg == 7'd1 || (re_reg == 32'd0 && im_reg == 32'd0)) begin
                    mv_next = 1'b1;
                    ml_next = 1'b1;
                    mk_next = 6'd0;
                    mre_next = (n_reg == 7'd1) ? re_reg : 32'd0;
                    mim_next = (n_reg == 7'd1) ? im_reg : 32'd0;
                    idx_next = n_reg - 7'd1;
                    state_next = S_OUT;
                end else if (im_reg == 32'd0) begin
                    u_next = re_reg[31] ? ANGLE_PI : 32'd0;
                    mag_next = re_reg[31] ? (32'd0 - re_reg) : re_reg;
                    state_next = S_DIV_B;
                end else if (re_reg == 32'd0) begin
                    u_next = im_reg[31] ? ANGLE_NEG_HP : ANGLE_HALF_PI;
                    mag_next = im_reg[31] ? (32'd0 - im_reg) : im_reg;
                    state_next = S_DIV_B;
                end else begin
                    x_next = XW'(signed'(re_reg)) <<< GUARD;
                    y_next = XW'(signed'(im_reg)) <<< GUARD;
                    z_next = '0;
                    if (re_reg[31]) begin
                        x_next = -(XW'(signed'(re_reg)) <<< GUARD);
                        y_next = -(XW'(signed'(im_reg)) <<< GUARD);
                        z_next = ZW'(ANGLE_PI);
                    end
                    i_next = 6'd0;
                    state_next = S_VEC;
                end
            end
            S_VEC: begin
                x_next = cx;  y_next = cy;  z_next = cz;
                i_next = i_reg + 6'd1;
                if (i_reg == LAST_STEP)
                    state_next = S_MG_LO;
            end
            S_MG_LO: state_next = S_MG_HI;
            S_MG_HI: begin
                lo_next = mul_p;
                state_next = S_MG_FIN;
            end
            S_MG_FIN: begin
                u_next = z_reg[31:0];
                mag_next = (|sum96[95:70]) ? 32'hFFFF_FFFF : sum96[69:38];
                state_next = S_DIV_B;
            end
            S_DIV_B: state_next = S_WAIT_B;
            S_WAIT_B: begin
                if (div_done) begin
                    base_next = arg_neg ? (32'd0 - div_q[31:0]) : div_q[31:0];
                    theta_next = arg_neg ? (32'd0 - div_q[31:0]) : div_q[31:0];
                    state_next = S_DIV_S;
                end
            end
            S_DIV_S: state_next = S_WAIT_S;
            S_WAIT_S: begin
                if (div_done) begin
                    step_next = div_q[31:0];
                    r_next = 32'd0;
                    bit_next = 5'd31;
                    state_next = S_RT_BIT;
                end
            end
            S_RT_BIT: begin
                c_next = r_reg | (32'd1 << bit_reg);
                p_next = 64'h1_0000_0000;
                j_next = 7'd0;
                state_next = S_RT_LO;
            end
            S_RT_LO: state_next = S_RT_HI;
            S_RT_HI: begin
                lo_next = mul_p;
                state_next = S_RT_CHK;
            end
            S_RT_CHK: begin
                if (q96 > {32'd0, target} || j_reg + 7'd1 == n_reg) begin
                    if (!(q96 > {32'd0, target}))
                        r_next = c_reg;
                    if (bit_reg == 5'd0)
                        state_next = S_X0_MUL;
                    else begin
                        bit_next = bit_reg - 5'd1;
                        state_next = S_RT_BIT;
                    end
                end else begin
                    p_next = q96[63:0];
                    j_next = j_reg + 7'd1;
                    state_next = S_RT_LO;
                end
            end
            S_X0_MUL: state_next = S_X0_FIN;
            S_X0_FIN: begin
                x0_next = mul_p[61:22];
                state_next = S_ROT_INIT;
            end
            S_ROT_INIT: begin
                flip_next = (theta_reg + ANGLE_HALF_PI) >= ANGLE_PI;
                z_next = ((theta_reg + ANGLE_HALF_PI) >= ANGLE_PI)
                         ? ZW'(signed'(th_flip)) : ZW'(signed'(theta_reg));
                x_next = signed'(XW'(x0_reg));
                y_next = '0;
                i_next = 6'd0;
                state_next = S_ROT;
            end
            S_ROT: begin
                x_next = cx;  y_next = cy;  z_next = cz;
                i_next = i_reg + 6'd1;
                if (i_reg == LAST_STEP)
                    state_next = S_ROT_FIN;
            end
            S_ROT_FIN: begin
                mv_next = 1'b1;
                mk_next = idx_reg[5:0];
                ml_next = (idx_reg + 7'd1 == n_reg);
                mre_next = round_sat(xf);
                mim_next = round_sat(yf);
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_ready) begin
                    mv_next = 1'b0;
                    if (ml_reg)
                        state_next = S_IDLE;
                    else begin
                        idx_next = idx_reg + 7'd1;
                        theta_next = theta_reg + step_reg;
                        state_next = S_ROT_INIT;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
        n_reg <= n_next;  re_reg <= re_next;  im_reg <= im_next;
        x_reg <= x_next;  y_reg <= y_next;  z_reg <= z_next;  i_reg <= i_next;
        u_reg <= u_next;  mag_reg <= mag_next;
        base_reg <= base_next;  step_reg <= step_next;  theta_reg <= theta_next;
        r_reg <= r_next;  c_reg <= c_next;  p_reg <= p_next;  lo_reg <= lo_next;
        bit_reg <= bit_next;  j_reg <= j_next;  idx_reg <= idx_next;
        x0_reg <= x0_next;  flip_reg <= flip_next;
        ml_reg <= ml_next;  mk_reg <= mk_next;
        mre_reg <= mre_next;  mim_reg <= mim_next;
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = mv_reg;
    assign m_root_index = mk_reg;
    assign m_real_out   = mre_reg;
    assign m_imag_out   = mim_reg;
    assign m_last       = ml_reg;
endmodule

@@ rtl/cnr_mul.sv @@
// cnr_mul: shared 32x32 unsigned multiplier with registered product.
// Depends on nothing.
module cnr_mul (
    input  logic        aclk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] prod
);
    logic [63:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= 64'(a) * 64'(b);
    end

    assign prod = prod_reg;
endmodule

@@ rtl/cnr_cordic_step.sv @@
// cnr_cordic_step: one CORDIC micro-rotation, shared by vectoring and rotation.
// Depends on cnr_pkg.
module cnr_cordic_step
    import cnr_pkg::*;
(
    input  logic signed [XW-1:0] x_in,
    input  logic signed [XW-1:0] y_in,
    input  logic signed [ZW-1:0] z_in,
    input  logic        [4:0]    shift,
    input  logic                 cw,
    output logic signed [XW-1:0] x_out,
    output logic signed [XW-1:0] y_out,
    output logic signed [ZW-1:0] z_out
);
    logic signed [XW-1:0] dx, dy;
    logic signed [ZW-1:0] da;

    always_comb begin
        dx = y_in >>> shift;
        dy = x_in >>> shift;
        da = signed'({2'b00, cnr_atan(shift)});
        if (cw) begin
            x_out = x_in + dx;
            y_out = y_in - dy;
            z_out = z_in + da;
        end else begin
            x_out = x_in - dx;
            y_out = y_in + dy;
            z_out = z_in - da;
        end
    end
endmodule

@@ rtl/cnr_div.sv @@
// cnr_div: restoring divider, 33-bit dividend by 7-bit divisor, one bit per cycle.
// Depends on nothing.
module cnr_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [32:0] dividend,
    input  logic [6:0]  divisor,
    output logic        done,
    output logic [32:0] quotient
);
    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [32:0] quo_reg, quo_next;
    logic [7:0]  rem_reg, rem_next;
    logic [6:0]  dvs_reg, dvs_next;
    logic [7:0]  rem_sh;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        rem_sh    = {rem_reg[6:0], quo_reg[32]};
        done      = busy_reg && (cnt_reg == 6'd0);
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 6'd33;
            quo_next  = dividend;
            rem_next  = 8'd0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (cnt_reg == 6'd0) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg - 6'd1;
                if (rem_sh >= {1'b0, dvs_reg}) begin
                    rem_next = rem_sh - {1'b0, dvs_reg};
                    quo_next = {quo_reg[31:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[31:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
endmodule

@@ rtl/cnr_checker.sv @@
// cnr_checker: port-level assertions for complex_nth_roots, bound to the top level.
// Depends on complex_nth_roots.
module cnr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [6:0]  s_degree,
    input logic [31:0] s_real_in,
    input logic [31:0] s_imag_in,
    input logic        m_valid,
    input logic        m_ready,
    input logic [5:0]  m_root_index,
    input logic [31:0] m_real_out,
    input logic [31:0] m_imag_out,
    input logic        m_last
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_real_out) && $stable(m_imag_out)
            && $stable(m_root_index) && $stable(m_last))
        else $error("result changed while stalled");

    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while result pending");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready after input transaction");

    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last |=> s_ready)
        else $error("not idle after last root");

    a_more: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> !s_ready)
        else $error("idle before last root");
endmodule

bind complex_nth_roots cnr_checker u_cnr_checker (.*);

@@ sim/tb_top.sv @@
// tb_top: self-checking testbench for complex_nth_roots (n-th roots of a complex value).
// Depends on cnr_pkg and the complex_nth_roots RTL; holds a scoreboard class and the
// bit-accurate root predictor.
`timescale 1ns / 100ps

class root_scoreboard;
    typedef struct {
        logic [5:0]  idx;
        logic [31:0] re;
        logic [31:0] im;
        logic        lst;
    } root_t;

    root_t pending[$];
    int    mismatches;

    static function logic [31:0] atan_step(int i);
        logic [31:0] t[32] = '{
            32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
            32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
            32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
            32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
            32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
            32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
            32'h00000001, 32'h00000000};
        return t[i];
    endfunction

    // floor(a*b >> sh), saturating to all ones
    static function logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int sh);
        logic [127:0] p;
        p = a * b;
        p = p >> sh;
        if (p[127:64] != 0) return '1;
        return p[63:0];
    endfunction

    static function logic [31:0] sat_round(longint v);
        longint s;
        s = (v + 128) >>> 8;
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        return s[31:0];
    endfunction

    static function logic [31:0] magnitude_root(logic [31:0] mag, int n);
        logic [63:0] tgt, p, c;
        logic [31:0] r;
        bit ok;
        tgt = {32'd0, mag} << 16;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            c = {32'd0, r | (32'd1 << b)};
            p = 64'd1 << 32;
            ok = 1;
            for (int j = 0; j < n && ok; j++) begin
                p = mul_shift(p, c, 16);
                if (p > tgt) ok = 0;
            end
            if (ok) r = c[31:0];
        end
        return r;
    endfunction

    function void note_input(logic [6:0] deg, logic [31:0] rin, logic [31:0] iin);
        int n;
        longint re, im, x, y, dx, dy, z, arg;
        logic [31:0] u, mag, r, base, stp, th;
        logic [63:0] m;
        bit flip;
        root_t e;
        n = deg;
        re = longint'($signed(rin));
        im = longint'($signed(iin));
        if (n == 0) n = 1;
        if (n > 64) n = 64;
        if (n == 1 || (re == 0 && im == 0)) begin
            e.idx = 0; e.lst = 1;
            e.re = (n == 1) ? rin : 0;
            e.im = (n == 1) ? iin : 0;
            pending = {pending, e};
            return;
        end
        if (im == 0) begin
            u = (re > 0) ? 32'd0 : cnr_pkg::ANGLE_PI;
            mag = (re > 0) ? re[31:0] : 32'(-re);
        end else if (re == 0) begin
            u = (im > 0) ? cnr_pkg::ANGLE_HALF_PI : cnr_pkg::ANGLE_NEG_HP;
            mag = (im > 0) ? im[31:0] : 32'(-im);
        end else begin
            x = re <<< 8; y = im <<< 8; u = 0;
            if (x < 0) begin
                x = -x; y = -y; u = cnr_pkg::ANGLE_PI;
            end
            for (int i = 0; i < 24; i++) begin
                dx = y >>> i; dy = x >>> i;
                if (y > 0) begin
                    x += dx; y -= dy; u += atan_step(i);
                end else begin
                    x -= dx; y += dy; u -= atan_step(i);
                end
            end
            m = mul_shift(x, 64'(cnr_pkg::KINV_Q30), 38);
            mag = (m > 64'hFFFFFFFF) ? 32'hFFFFFFFF : m[31:0];
        end
        arg = (u > cnr_pkg::ANGLE_PI) ? longint'(u) - 64'sh100000000 : longint'(u);
        r = magnitude_root(mag, n);
        base = 32'(arg / n);
        stp = 32'(64'h100000000 / n);
        for (int k = 0; k < n; k++) begin
            th = base + 32'(k) * stp;
            x = longint'(mul_shift(r, 64'(cnr_pkg::KINV_Q30), 22));
            y = 0; flip = 0;
            if (32'(th + cnr_pkg::ANGLE_HALF_PI) >= cnr_pkg::ANGLE_PI) begin
                th -= cnr_pkg::ANGLE_PI; flip = 1;
            end
            z = longint'($signed(th));
            for (int i = 0; i < 24; i++) begin
                dx = y >>> i; dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= atan_step(i);
                end else begin
                    x += dx; y -= dy; z += atan_step(i);
                end
            end
            if (flip) begin
                x = -x; y = -y;
            end
            e.idx = 6'(k); e.re = sat_round(x); e.im = sat_round(y);
            e.lst = (k + 1 == n);
            pending = {pending, e};
        end
    endfunction

    function void check_root(logic [5:0] idx, logic [31:0] re, logic [31:0] im,
                             logic lst);
        root_t e;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected root k=%0d re=%h im=%h last=%b", idx, re, im, lst);
            return;
        end
        e = pending.pop_front();
        if (idx !== e.idx || re !== e.re || im !== e.im || lst !== e.lst) begin
            mismatches++;
            if (mismatches <= 10)
                $display("root mismatch: exp k=%0d re=%h im=%h last=%b, got k=%0d re=%h im=%h last=%b",
                         e.idx, e.re, e.im, e.lst, idx, re, im, lst);
        end
    endfunction
endclass

module tb_top;
    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [6:0]  s_degree = 0;
    logic [31:0] s_real_in = 0;
    logic [31:0] s_imag_in = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [5:0]  m_root_index;
    logic [31:0] m_real_out;
    logic [31:0] m_imag_out;
    logic        m_last;

    root_scoreboard sb = new();
    bit  quiet_phase = 0;
    bit  hold_off = 0;
    bit  stim_done = 0;
    int  idle_cycles = 0;
    localparam int WATCHDOG = 40000;

    always #4 aclk = ~aclk;

    complex_nth_roots u_dut (.*);

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sb.note_input(s_degree, s_real_in, s_imag_in);
        if (aresetn && m_valid && m_ready)
            sb.check_root(m_root_index, m_real_out, m_imag_out, m_last);
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    always @(posedge aclk) begin
        if (idle_cycles > WATCHDOG) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_radicand(logic [6:0] deg, logic [31:0] re, logic [31:0] im);
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
        s_valid <= 1; s_degree <= deg; s_real_in <= re; s_imag_in <= im;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_part();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            3: return 32'($signed($urandom_range(0, 400000)) - 200000);
            default: return $urandom();
        endcase
    endfunction

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_ready <= 0;
                repeat (3000) @(negedge aclk);
                hold_off = 0;
            end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                m_ready <= 0;
                repeat ($urandom_range(1, 8) - 1) @(negedge aclk);
            end else begin
                m_ready <= 1;
            end
        end
    end

    initial begin
        logic [6:0] dg;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        send_radicand(7'd1, 32'h8000_0000, 32'h7FFF_FFFF);
        send_radicand(7'd0, 32'h0001_0000, 32'hFFFF_0000);
        send_radicand(7'd5, 32'd0, 32'd0);
        send_radicand(7'd127, 32'd0, 32'd0);
        send_radicand(7'd2, 32'h0004_0000, 32'd0);
        send_radicand(7'd3, 32'hFFF8_0000, 32'd0);
        send_radicand(7'd4, 32'd0, 32'h0001_0000);
        send_radicand(7'd2, 32'd0, 32'hFFFF_0000);
        send_radicand(7'd64, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_radicand(7'd100, 32'h8000_0000, 32'h8000_0000);
        send_radicand(7'd3, 32'h8000_0000, 32'h7FFF_FFFF);
        send_radicand(7'd2, 32'hFFFF_0000, 32'hFFFF_0000);
        send_radicand(7'd6, 32'h0000_0001, 32'hFFFF_FFFF);
        send_radicand(7'd65, 32'h8000_0000, 32'd0);
        hold_off = 1;
        for (int i = 0; i < 4; i++) send_radicand(7'd3, 32'h0002_0000, 32'h0003_0000);
        for (int i = 0; i < 170; i++) begin
            if (i == 140) quiet_phase = 1;
            case ($urandom_range(0, 9))
                0: dg = 7'($urandom_range(0, 127));
                1: dg = 7'($urandom_range(33, 64));
                default: dg = 7'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 9))
                0: send_radicand(dg, rand_part(), 32'd0);
                1: send_radicand(dg, 32'd0, rand_part());
                2: send_radicand(dg, 32'd0, 32'd0);
                default: send_radicand(dg, rand_part(), rand_part());
            endcase
        end
        s_valid <= 0;
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (sb.mismatches == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule
